// ----- rtl/core/plse_pkg.sv -----
// Shared constants for the pooled linked stack engine: field widths, request
// codes, status codes and parameter defaults. No dependencies.
package plse_pkg;

   localparam int POOL_NODES_DEF = 64;
   localparam int NUM_LISTS_DEF  = 4;

   localparam int KEY_W    = 64;
   localparam int PAY_W    = 64;
   localparam int OP_W     = 2;
   localparam int LID_IN_W = 2;
   localparam int STAT_W   = 2;

   // Beat layouts on the streaming ports.
   localparam int DATA_W     = KEY_W + PAY_W;
   localparam int REQ_USER_W = OP_W + LID_IN_W;
   localparam int RSP_USER_W = STAT_W;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- rtl/core/plse_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for every node store of the engine.
module plse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/core/pooled_linked_stack_engine.sv -----
// Pooled linked stack engine: sequencer, list heads, free list and result register.
// Depends on plse_pkg and plse_ram (link, key and payload stores).
//
// A pool of POOL_NODES nodes holds NUM_LISTS stacks and a free list. Each request beat
// names a list and an operation: push, pop, peek or sorted insert (keys ascend from the
// top, compared as unsigned big-endian strings). The block takes one request at a time; a
// push passes through S_TAKE, a pop through S_POP and a peek through S_PEEK; a refusal
// (full pool, empty list) skips these; a sorted insert passes through S_TAKE, S_WALK
// while it passes over elements, and S_LINK. A list holds at most POOL_NODES - 1 elements
// when a node is still free, so an insert passes over at most POOL_NODES - 1 elements.
// The walk is set by the single read port of the node stores and the one key comparator,
// which see one node per cycle. No clearing pass is needed after reset: nodes never taken
// from the pool are tracked by a count, so the block is ready at once. A finished result
// waits in an output register while the next request is accepted.
module pooled_linked_stack_engine #(
   parameter int POOL_NODES = plse_pkg::POOL_NODES_DEF,
   parameter int NUM_LISTS  = plse_pkg::NUM_LISTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // elem_key [63:0], elem_payload [127:64]
   input  logic [plse_pkg::DATA_W-1:0]     req_tdata,
   // req_type [1:0], list_id [3:2]
   input  logic [plse_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_key [63:0], out_payload [127:64]
   output logic [plse_pkg::DATA_W-1:0]     rsp_tdata,
   // status [1:0]
   output logic [plse_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import plse_pkg::*;

   localparam int AW     = $clog2(POOL_NODES);
   localparam int LINK_W = AW + 1;
   localparam int LID_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam logic [LINK_W-1:0] NULL_LINK = '1;
   localparam logic [LINK_W-1:0] POOL_SIZE = LINK_W'(POOL_NODES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TAKE = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_PEEK = 3'd3;
   localparam logic [2:0] S_WALK = 3'd4;
   localparam logic [2:0] S_LINK = 3'd5;
   localparam logic [2:0] S_RESP = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [LID_W-1:0]  lid_ff, lid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [LINK_W-1:0] top_ff, top_in;
   logic [LINK_W-1:0] node_ff, node_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] steps_ff, steps_in;
   logic [LINK_W-1:0] free_ff, free_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;
   logic [LINK_W-1:0] heads_ff [NUM_LISTS];

   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic [PAY_W-1:0]  res_pay_ff, res_pay_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0]  rsp_pay_ff, rsp_pay_in;

   logic              head_we;
   logic [LINK_W-1:0] head_wdata;

   logic              data_we;
   logic              link_we;
   logic [AW-1:0]     link_waddr;
   logic [LINK_W-1:0] link_wdata;
   logic [AW-1:0]     rd_addr;
   logic [LINK_W-1:0] rd_link;
   logic [KEY_W-1:0]  rd_key;
   logic [PAY_W-1:0]  rd_pay;

   logic [OP_W-1:0]     req_op;
   logic [LID_IN_W-1:0] req_lid;
   logic [LID_W-1:0]    req_lid_idx;
   logic                req_lid_ok;
   logic [LINK_W-1:0]   req_top;
   logic                accept;
   logic                res_load;
   logic [LINK_W-1:0]   next_free;
   logic                walk_done;

   assign req_op      = req_tuser[OP_W-1:0];
   assign req_lid     = req_tuser[REQ_USER_W-1:OP_W];
   assign req_lid_idx = LID_W'(req_lid);
   assign req_lid_ok  = 32'(req_lid) < NUM_LISTS;
   assign req_top     = req_lid_ok ? heads_ff[req_lid_idx] : NULL_LINK;
   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign res_load    = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // A node below the fresh count has never left the pool, so its link is still the
   // reset chain (one below itself) and the store holds nothing for it.
   assign next_free = (node_ff < fresh_ff)
                    ? ((node_ff == '0) ? NULL_LINK : LINK_W'(node_ff - 1'b1))
                    : rd_link;

   assign walk_done = !(cur_ff < POOL_SIZE) || !(steps_ff < POOL_SIZE) || !(rd_key < key_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lid_in        = lid_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      top_in        = top_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      free_in       = free_ff;
      fresh_in      = fresh_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      head_we       = 1'b0;
      head_wdata    = node_ff;
      data_we       = 1'b0;
      link_we       = 1'b0;
      link_waddr    = node_ff[AW-1:0];
      link_wdata    = top_ff;
      rd_addr       = cur_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            rd_addr = free_ff[AW-1:0];
            if (accept) begin
               op_in         = req_op;
               lid_in        = req_lid_idx;
               key_in        = req_tdata[KEY_W-1:0];
               pay_in        = req_tdata[DATA_W-1:KEY_W];
               top_in        = req_top;
               node_in       = free_ff;
               res_status_in = ST_OK;
               res_key_in    = '0;
               res_pay_in    = '0;
               state_in      = S_RESP;
               if (!req_lid_ok) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  case (req_op)
                     OP_PUSH, OP_INSERT: begin
                        if (free_ff < POOL_SIZE) begin
                           state_in = S_TAKE;
                        end else begin
                           res_status_in = ST_FULL;
                        end
                     end
                     default: begin
                        rd_addr = req_top[AW-1:0];
                        if (req_top < POOL_SIZE) begin
                           state_in = (req_op == OP_POP) ? S_POP : S_PEEK;
                        end else begin
                           res_status_in = ST_EMPTY;
                        end
                     end
                  endcase
               end
            end
         end
         S_TAKE: begin
            free_in = next_free;
            if (node_ff < fresh_ff) begin
               fresh_in = node_ff;
            end
            data_we = 1'b1;
            if (op_ff == OP_PUSH) begin
               link_we  = 1'b1;
               head_we  = 1'b1;
               state_in = S_RESP;
            end else begin
               prev_in  = NULL_LINK;
               cur_in   = top_ff;
               steps_in = '0;
               rd_addr  = top_ff[AW-1:0];
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // One node per cycle: the link just read addresses the next read.
            if (walk_done) begin
               link_we    = 1'b1;
               link_wdata = cur_ff;
               state_in   = S_LINK;
            end else begin
               prev_in  = cur_ff;
               cur_in   = rd_link;
               steps_in = steps_ff + 1'b1;
               rd_addr  = rd_link[AW-1:0];
            end
         end
         S_LINK: begin
            if (prev_ff < POOL_SIZE) begin
               link_we    = 1'b1;
               link_waddr = prev_ff[AW-1:0];
               link_wdata = node_ff;
            end else begin
               head_we = 1'b1;
            end
            state_in = S_RESP;
         end
         S_POP: begin
            res_key_in = rd_key;
            res_pay_in = rd_pay;
            head_we    = 1'b1;
            head_wdata = rd_link;
            link_we    = 1'b1;
            link_waddr = top_ff[AW-1:0];
            link_wdata = free_ff;
            free_in    = top_ff;
            state_in   = S_RESP;
         end
         S_PEEK: begin
            res_key_in = rd_key;
            res_pay_in = rd_pay;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (res_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      if (res_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_key_in    = res_key_ff;
         rsp_pay_in    = res_pay_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= LINK_W'(POOL_NODES - 1);
         fresh_ff     <= POOL_SIZE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            heads_ff[i] <= NULL_LINK;
         end
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            heads_ff[lid_ff] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      lid_ff        <= lid_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      top_ff        <= top_in;
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
   end

   plse_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_link)
   );

   plse_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_key_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (node_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   plse_ram #(.WIDTH(PAY_W), .DEPTH(POOL_NODES)) u_pay_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (node_ff[AW-1:0]),
      .wr_data (pay_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_pay)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pay_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The free head is always a pool node or null, and the fresh count never grows.
   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      (free_ff < POOL_SIZE) || (free_ff == NULL_LINK))
      else $error("free list head outside the pool");

   a_fresh_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> (fresh_ff <= $past(fresh_ff)))
      else $error("fresh node count grew");

   a_full_means_no_free: assert property (@(posedge clock) disable iff (reset)
      (res_load && (res_status_ff == ST_FULL)) |-> (free_ff == NULL_LINK))
      else $error("pool full reported while a free node exists");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (steps_ff <= POOL_SIZE))
      else $error("sorted insert walked past the pool size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while the previous one is still at work");

endmodule

// ----- bench/pooled_linked_stack_engine_tb.sv -----
// Self-checking testbench for pooled_linked_stack_engine: directed and random request
// beats checked against a behavioural model of the node pool, stacks and free list.
// Depends on plse_pkg and the engine RTL only.
`timescale 1ns / 100ps

module pooled_linked_stack_engine_tb;
   import plse_pkg::*;

   localparam int POOL_NODES     = POOL_NODES_DEF;
   localparam int NUM_LISTS      = NUM_LISTS_DEF;
   localparam int NIL_NODE       = -1;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int BURST_LEN      = 40;

   typedef enum int {GROW, SHRINK, BALANCED} traffic_bias_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  key;
      logic [PAY_W-1:0]  payload;
   } stack_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // Shadow copy of the pool: links, stored elements, free list and stack tops.
   int               node_next [POOL_NODES];
   logic [KEY_W-1:0] node_key  [POOL_NODES];
   logic [PAY_W-1:0] node_pay  [POOL_NODES];
   int               free_top;
   int               list_top  [NUM_LISTS];

   stack_result_type pending_results [$];
   int               error_count    = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_tickets   = 0;
   int               hold_taken     = 0;
   int               hold_left      = 0;
   int               quiet_cycles   = 0;

   pooled_linked_stack_engine #(
      .POOL_NODES (POOL_NODES),
      .NUM_LISTS  (NUM_LISTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void pool_reset();
      for (int i = 0; i < POOL_NODES; i++) begin
         node_next[i] = i - 1;
         node_key[i]  = '0;
         node_pay[i]  = '0;
      end
      free_top = POOL_NODES - 1;
      for (int l = 0; l < NUM_LISTS; l++) begin
         list_top[l] = NIL_NODE;
      end
   endfunction

   function automatic stack_result_type pool_apply(input logic [OP_W-1:0] op,
                                                   input logic [LID_IN_W-1:0] lid,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [PAY_W-1:0] pay);
      stack_result_type res;
      int               top;
      int               node;
      int               prev;
      int               cur;
      int               steps;
      res.status  = ST_OK;
      res.key     = '0;
      res.payload = '0;
      if (int'(lid) >= NUM_LISTS) begin
         res.status = ST_EMPTY;
         return res;
      end
      top = list_top[lid];
      case (op)
         OP_PUSH: begin
            if (free_top == NIL_NODE) begin
               res.status = ST_FULL;
            end else begin
               node            = free_top;
               free_top        = node_next[node];
               node_key[node]  = key;
               node_pay[node]  = pay;
               node_next[node] = top;
               list_top[lid]   = node;
            end
         end
         OP_POP: begin
            if (top == NIL_NODE) begin
               res.status = ST_EMPTY;
            end else begin
               res.key        = node_key[top];
               res.payload    = node_pay[top];
               list_top[lid]  = node_next[top];
               node_next[top] = free_top;
               free_top       = top;
            end
         end
         OP_PEEK: begin
            if (top == NIL_NODE) begin
               res.status = ST_EMPTY;
            end else begin
               res.key     = node_key[top];
               res.payload = node_pay[top];
            end
         end
         default: begin
            if (free_top == NIL_NODE) begin
               res.status = ST_FULL;
            end else begin
               node           = free_top;
               free_top       = node_next[node];
               node_key[node] = key;
               node_pay[node] = pay;
               prev           = NIL_NODE;
               cur            = top;
               steps          = 0;
               // Walk past every element whose key is strictly smaller.
               while (cur != NIL_NODE && steps < POOL_NODES && node_key[cur] < key) begin
                  prev  = cur;
                  cur   = node_next[cur];
                  steps = steps + 1;
               end
               node_next[node] = cur;
               if (prev != NIL_NODE) begin
                  node_next[prev] = node;
               end else begin
                  list_top[lid] = node;
               end
            end
         end
      endcase
      return res;
   endfunction

   // Packs a city name big-endian into eight bytes, padded with NUL.
   function automatic logic [KEY_W-1:0] city_code(input string name);
      logic [KEY_W-1:0] code;
      code = '0;
      for (int i = 0; i < 8; i++) begin
         code = {code[KEY_W-9:0], (i < name.len()) ? name[i] : 8'h00};
      end
      return code;
   endfunction

   function automatic logic [KEY_W-1:0] letters_key(input int len, input int span);
      logic [KEY_W-1:0] code;
      code = '0;
      for (int i = 0; i < 8; i++) begin
         code = {code[KEY_W-9:0], (i < len) ? 8'(8'h41 + $urandom_range(span - 1)) : 8'h00};
      end
      return code;
   endfunction

   // Short names from a three-letter alphabet give frequent equal keys.
   function automatic logic [KEY_W-1:0] random_city_key();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return {$urandom, $urandom};
         4, 5, 6: return letters_key($urandom_range(3, 1), 3);
         default: return letters_key($urandom_range(8, 1), 26);
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [LID_IN_W-1:0] lid,
                               input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pay, key};
      req_tuser  <= {lid, op};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(pool_apply(op, lid, key, pay));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_lists();
      send_request(OP_PEEK, 2'd0, '1, '1);
      send_request(OP_POP, 2'd3, '1, '0);
   endtask

   task automatic test_push_pop_extremes();
      send_request(OP_PUSH, 2'd0, '0, '0);
      send_request(OP_PUSH, 2'd0, '1, '1);
      send_request(OP_PEEK, 2'd0, '0, '0);
      send_request(OP_POP, 2'd0, '0, '0);
      send_request(OP_POP, 2'd0, '0, '0);
      send_request(OP_POP, 2'd0, '0, '0);
   endtask

   task automatic test_sorted_insert();
      send_request(OP_INSERT, 2'd1, city_code("PARIS"), 64'h1111_0000_0000_0001);
      send_request(OP_INSERT, 2'd1, city_code("BERLIN"), 64'h2222_0000_0000_0002);
      send_request(OP_INSERT, 2'd1, city_code("ROME"), 64'h3333_0000_0000_0003);
      // An equal key must land in front of the existing PARIS element.
      send_request(OP_INSERT, 2'd1, city_code("PARIS"), 64'h4444_0000_0000_0004);
      send_request(OP_INSERT, 2'd1, '0, 64'h5555_0000_0000_0005);
      send_request(OP_INSERT, 2'd1, '1, 64'h6666_0000_0000_0006);
      repeat (6) send_request(OP_POP, 2'd1, '0, '0);
   endtask

   task automatic test_all_lists();
      send_request(OP_PUSH, 2'd2, city_code("OSLO"), {$urandom, $urandom});
      send_request(OP_PUSH, 2'd3, city_code("LIMA"), {$urandom, $urandom});
      send_request(OP_PEEK, 2'd2, '0, '0);
      send_request(OP_POP, 2'd3, '0, '0);
   endtask

   // Fills the whole pool, each node by sorted insert on list 0 or by push onto a random
   // list, tries both allocating operations against a full pool and then empties every stack.
   task automatic test_pool_exhaust();
      while (free_top != NIL_NODE) begin
         if ($urandom_range(1)) begin
            send_request(OP_INSERT, 2'd0, random_city_key(), {$urandom, $urandom});
         end else begin
            send_request(OP_PUSH, 2'($urandom_range(3)), random_city_key(), {$urandom, $urandom});
         end
      end
      send_request(OP_PUSH, 2'd1, random_city_key(), {$urandom, $urandom});
      send_request(OP_INSERT, 2'd0, random_city_key(), {$urandom, $urandom});
      for (int l = 0; l < NUM_LISTS; l++) begin
         while (list_top[l] != NIL_NODE) begin
            send_request(OP_POP, 2'(l), '0, '0);
         end
      end
   endtask

   // The receiver stops for a long stretch while beats keep coming, so the
   // output register and the sequencer fill and the request side stalls.
   task automatic test_output_backpressure();
      hold_tickets = hold_tickets + 1;
      repeat (24) begin
         send_request(2'($urandom_range(3)), 2'($urandom_range(3)), random_city_key(),
                      {$urandom, $urandom});
      end
   endtask

   task automatic test_random_traffic(input int beats);
      traffic_bias_type    bias;
      int                  focus;
      int                  pick;
      logic [OP_W-1:0]     op;
      logic [LID_IN_W-1:0] lid;
      bias  = BALANCED;
      focus = 0;
      for (int n = 0; n < beats; n++) begin
         if (n % BURST_LEN == 0) begin
            bias  = traffic_bias_type'($urandom_range(2));
            focus = $urandom_range(NUM_LISTS - 1);
         end
         pick = $urandom_range(99);
         case (bias)
            GROW:    op = (pick < 35) ? OP_PUSH : (pick < 70) ? OP_INSERT :
                          (pick < 85) ? OP_PEEK : OP_POP;
            SHRINK:  op = (pick < 10) ? OP_PUSH : (pick < 20) ? OP_INSERT :
                          (pick < 35) ? OP_PEEK : OP_POP;
            default: op = 2'(pick % 4);
         endcase
         // Most beats go to one list so that sorted walks get long.
         lid = ($urandom_range(99) < 70) ? 2'(focus) : 2'($urandom_range(3));
         send_request(op, lid, random_city_key(), {$urandom, $urandom});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_taken != hold_tickets) begin
         hold_taken <= hold_tickets;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      stack_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing outstanding: status %0d key %h payload %h",
                   rsp_tuser, rsp_tdata[KEY_W-1:0], rsp_tdata[DATA_W-1:KEY_W]);
            error_count = error_count + 1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count = error_count + 1;
            end
            if (rsp_tdata[KEY_W-1:0] !== want.key) begin
               $error("out_key: expected %h, got %h", want.key, rsp_tdata[KEY_W-1:0]);
               error_count = error_count + 1;
            end
            if (rsp_tdata[DATA_W-1:KEY_W] !== want.payload) begin
               $error("out_payload: expected %h, got %h", want.payload,
                      rsp_tdata[DATA_W-1:KEY_W]);
               error_count = error_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      pool_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_lists();
      test_push_pop_extremes();
      test_sorted_insert();
      test_all_lists();
      drain_results();

      test_pool_exhaust();
      drain_results();

      test_output_backpressure();
      drain_results();

      test_random_traffic(290);
      drain_results();

      send_idle_pct = 83;
      test_random_traffic(290);
      drain_results();

      send_idle_pct  = 0;
      recv_stall_pct = 83;
      test_random_traffic(290);
      drain_results();

      send_idle_pct  = 16;
      recv_stall_pct = 16;
      test_random_traffic(290);
      drain_results();

      // Give a stray late beat time to show up before the verdict.
      repeat (POOL_NODES + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/plse_pkg.sv
rtl/core/plse_ram.sv
rtl/core/pooled_linked_stack_engine.sv
bench/pooled_linked_stack_engine_tb.sv
